@@ rtl/lmsd_pkg.sv @@
// Shared types and constants for the LED matrix scan driver.
// No dependencies; imported by every rtl module of the block.
`timescale 1ns / 1ps
package lmsd_pkg;

	localparam int ROW_COUNT_DEF    = 8;
	localparam int COLUMN_COUNT_DEF = 16;

	localparam int ROWSEL_BITS = 8;
	localparam int COL_BITS    = 16;
	localparam int FRAME_BITS  = ROWSEL_BITS + COL_BITS;
	localparam int POS_W       = 5;
	localparam int ROW_IDX_W   = 3;
	localparam int PERIOD_W    = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(2);
	localparam logic [POS_W-1:0]    LAST_POS     = POS_W'(FRAME_BITS - 1);

	localparam logic [1:0] REG_SCAN_PERIOD = 2'd0;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_SET   = 2'd1,
		KIND_CLEAR = 2'd2
	} kind_t;

	// front end -> queue
	typedef struct packed {
		logic                  push;
		logic [FRAME_BITS-1:0] word;
	} scan_push_t;

	// queue -> back end
	typedef struct packed {
		logic                  avail;
		logic [FRAME_BITS-1:0] word;
	} scan_head_t;

endpackage

@@ rtl/lmsd_front.sv @@
// Front end: takes input items, keeps the frame buffer and tick counter,
// and builds a 24-bit scan word for every scanning tick. Uses lmsd_pkg.
`timescale 1ns / 1ps
module lmsd_front
	import lmsd_pkg::*;
#(
	parameter int ROW_COUNT    = ROW_COUNT_DEF,
	parameter int COLUMN_COUNT = COLUMN_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [1:0]           kind,
	input  logic [3:0]           row,
	input  logic [4:0]           col,
	input  logic [PERIOD_W-1:0]  scan_period,
	output scan_push_t           push
);

	localparam int ROW_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

	logic [COLUMN_COUNT-1:0] frame_q [ROW_COUNT];
	logic [ROW_IDX_W-1:0]    scan_row_q;
	logic [PERIOD_W-1:0]     elapsed_q;

	logic [PERIOD_W-1:0]     elapsed_inc;
	logic                    is_tick, is_set, is_clear, scan_now;
	logic [ROWSEL_BITS-1:0]  rowsel;
	logic [COL_BITS-1:0]     cols;
	logic [ROW_IDX_W-1:0]    scan_row_next;

	assign is_tick  = accept && (kind == KIND_TICK);
	assign is_set   = accept && (kind == KIND_SET);
	assign is_clear = accept && (kind == KIND_CLEAR);

	// saturating millisecond count
	assign elapsed_inc = (elapsed_q == {PERIOD_W{1'b1}}) ? elapsed_q : elapsed_q + 1'b1;
	assign scan_now    = is_tick && (elapsed_inc >= scan_period);

	assign rowsel = ~(ROWSEL_BITS'(1) << scan_row_q);
	assign cols   = COL_BITS'(frame_q[scan_row_q[ROW_W-1:0]]);
	assign scan_row_next = (scan_row_q == ROW_IDX_W'(ROW_COUNT - 1)) ?
		'0 : scan_row_q + 1'b1;

	assign push.push = scan_now;
	assign push.word = {rowsel, cols};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_row_q <= '0;
			elapsed_q  <= '0;
		end else if (is_tick) begin
			if (scan_now) begin
				elapsed_q  <= '0;
				scan_row_q <= scan_row_next;
			end else begin
				elapsed_q <= elapsed_inc;
			end
		end
	end

	// out-of-range set items match no cell and fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROW_COUNT; r++) begin
				frame_q[r] <= '0;
			end
		end else if (is_clear) begin
			for (int r = 0; r < ROW_COUNT; r++) begin
				frame_q[r] <= '0;
			end
		end else if (is_set) begin
			for (int r = 0; r < ROW_COUNT; r++) begin
				for (int c = 0; c < COLUMN_COUNT; c++) begin
					if ((row == 4'(r)) && (col == 5'(c))) begin
						frame_q[r][c] <= 1'b1;
					end
				end
			end
		end
	end

endmodule

@@ rtl/lmsd_queue.sv @@
// Short FIFO of pending scan words between front and back end.
// Uses lmsd_pkg for depth and the push/head structs.
`timescale 1ns / 1ps
module lmsd_queue
	import lmsd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  scan_push_t push,
	input  logic       pop,
	output scan_head_t head,
	output logic       full
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [FRAME_BITS-1:0] entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]      count_q;
	logic                  do_push, do_pop;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head.avail = (count_q != '0);
	assign head.word  = entry_q[rd_ptr_q];

	assign do_push = push.push && !full;
	assign do_pop  = pop && head.avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/lmsd_back.sv @@
// Back end: serializes one scan word at a time, MSB first, one item per bit.
// Uses lmsd_pkg for the scan word width and the queue head struct.
`timescale 1ns / 1ps
module lmsd_back
	import lmsd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  scan_head_t       head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             serial_data,
	output logic [POS_W-1:0] bit_position,
	output logic             latch_after,
	output logic             last
);

	logic [FRAME_BITS-1:0] shift_q;
	logic [POS_W-1:0]      pos_q;
	logic                  busy_q;
	logic                  out_accept, at_end;

	assign out_accept = busy_q && out_ready;
	assign at_end     = (pos_q == LAST_POS);
	assign pop        = head.avail && (!busy_q || (out_accept && at_end));

	assign out_valid    = busy_q;
	assign serial_data  = shift_q[FRAME_BITS-1];
	assign bit_position = pos_q;
	assign latch_after  = at_end;
	assign last         = at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
		end else if (out_accept) begin
			if (at_end) begin
				busy_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			shift_q <= head.word;
		end else if (out_accept) begin
			shift_q <= {shift_q[FRAME_BITS-2:0], 1'b0};
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pos_q <= LAST_POS))
		else $error("bit position past end of scan word");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_accept && at_end) |=> (!busy_q || (pos_q == '0)))
		else $error("next scan did not start at bit zero");

	a_no_early_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !(out_accept && at_end)) |-> !pop)
		else $error("scan word loaded while a scan is still shifting");

endmodule

@@ rtl/led_matrix_scan_driver_top.sv @@
// Path: a scanning tick item is written into the scan queue, then loaded into the
//   serializer; its 24 bits then go out one per cycle while the sink is ready.
// Throughput: one input item per cycle while the scan queue (2 words) has room;
//   the serializer is the limit.
// Reset (arst_n low, async): frame buffer cleared, row 0, tick count 0,
//   scan_period 2, queue and serializer empty. No clearing pass is needed.
`timescale 1ns / 1ps
module led_matrix_scan_driver_top
	import lmsd_pkg::*;
#(
	parameter int ROW_COUNT    = ROW_COUNT_DEF,
	parameter int COLUMN_COUNT = COLUMN_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	// APB register port: scan_period at byte address 0
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [3:0] row, [8:4] col, [15:9] zero
	input  logic [1:0]  s_axis_tuser,   // [1:0] kind

	// result items, one per serial bit
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [0] serial_data, [5:1] bit_position,
	                                    // [6] latch_after, [7] zero
	output logic        m_axis_tlast    // last bit of a scan
);

	logic [PERIOD_W-1:0] scan_period_q;
	logic                cfg_write;
	logic                in_accept;
	logic                q_full, q_pop;
	scan_push_t          q_push;
	scan_head_t          q_head;
	logic                serial_data, latch_after;
	logic [POS_W-1:0]    bit_position;

	// register port, zero wait states
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready && (paddr == REG_SCAN_PERIOD);
	assign prdata    = (paddr == REG_SCAN_PERIOD) ? 32'(scan_period_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_period_q <= PERIOD_RESET;
		end else if (cfg_write) begin
			scan_period_q <= pwdata[PERIOD_W-1:0];
		end
	end

	// The front end may push on any accepted tick, so it is only held off
	// while the queue is full. Set/clear items could pass then, but keeping
	// tready off the payload keeps the handshake simple.
	assign s_axis_tready = !q_full;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	lmsd_front #(
		.ROW_COUNT    (ROW_COUNT),
		.COLUMN_COUNT (COLUMN_COUNT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_accept),
		.kind        (s_axis_tuser),
		.row         (s_axis_tdata[3:0]),
		.col         (s_axis_tdata[8:4]),
		.scan_period (scan_period_q),
		.push        (q_push)
	);

	lmsd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.pop    (q_pop),
		.head   (q_head),
		.full   (q_full)
	);

	// The serializer state itself is the output register: the queue keeps
	// the front end running while a scan waits on the sink.
	lmsd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.pop          (q_pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.serial_data  (serial_data),
		.bit_position (bit_position),
		.latch_after  (latch_after),
		.last         (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, latch_after, bit_position, serial_data};

endmodule

@@ bench/led_matrix_scan_driver_top_tb.sv @@
// Self-checking bench for led_matrix_scan_driver_top: drives items, APB writes and
// sink stalls, predicts every serial scan bit. Depends on rtl/lmsd_pkg.sv and the top.
`timescale 1ns / 1ps
module led_matrix_scan_driver_top_tb;
	import lmsd_pkg::*;

	// kind 3 has no package name; the block must ignore it
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [1:0] PERIOD_ADDR = 2'(4 * REG_SCAN_PERIOD);

	// one expected serial bit
	typedef struct {
		logic             data;
		logic [POS_W-1:0] pos;
		logic             latch;
		logic             last;
	} scan_bit_t;

	// Predicts the scan bits from accepted items and checks the bits that come out.
	class scan_frame_checker;
		logic [COL_BITS-1:0]  led_rows [ROWSEL_BITS];
		logic [ROW_IDX_W-1:0] next_row;
		logic [PERIOD_W-1:0]  ms_count;
		logic [PERIOD_W-1:0]  period;
		scan_bit_t            bits_due [$];
		int                   fail_count;

		function new();
			foreach (led_rows[r]) led_rows[r] = '0;
			next_row   = '0;
			ms_count   = '0;
			period     = PERIOD_RESET;
			fail_count = 0;
		endfunction

		function void complain(string msg);
			if (fail_count < 10)
				$display("%0t ns: %s", $realtime, msg);
			fail_count++;
		endfunction

		// queue the 24 bits of one row scan, MSB first, then step the row
		function void push_scan();
			logic [ROWSEL_BITS-1:0] row_sel;
			logic [FRAME_BITS-1:0]  word;
			scan_bit_t              b;
			row_sel = ~(ROWSEL_BITS'(1) << next_row);
			word    = {row_sel, led_rows[next_row]};
			for (int i = 0; i < FRAME_BITS; i++) begin
				b.data  = word[FRAME_BITS-1-i];
				b.pos   = POS_W'(i);
				b.latch = (b.pos == LAST_POS);
				b.last  = (b.pos == LAST_POS);
				bits_due.push_back(b);
			end
			next_row = (next_row == ROW_IDX_W'(ROW_COUNT_DEF - 1)) ? '0 : next_row + 1'b1;
		endfunction

		function void take_item(logic [1:0] kind, logic [3:0] row, logic [4:0] col);
			case (kind)
			KIND_TICK: begin
				if (ms_count != '1)
					ms_count++;
				// a period of zero behaves like one: always met after the increment
				if (ms_count >= period) begin
					ms_count = '0;
					push_scan();
				end
			end
			KIND_SET: begin
				if (row < ROW_COUNT_DEF && col < COLUMN_COUNT_DEF)
					led_rows[row[2:0]][col[3:0]] = 1'b1;
			end
			KIND_CLEAR: begin
				foreach (led_rows[r]) led_rows[r] = '0;
			end
			default: ;
			endcase
		endfunction

		function void check_bit(logic data, logic [POS_W-1:0] pos, logic latch, logic last);
			scan_bit_t want;
			if (bits_due.size() == 0) begin
				complain($sformatf("unexpected bit: data %0b pos %0d latch %0b last %0b",
					data, pos, latch, last));
				return;
			end
			want = bits_due.pop_front();
			if (data !== want.data || pos !== want.pos || latch !== want.latch ||
			    last !== want.last)
				complain($sformatf({"bit mismatch: expected data %0b pos %0d latch %0b last %0b,",
					" got data %0b pos %0d latch %0b last %0b"},
					want.data, want.pos, want.latch, want.last, data, pos, latch, last));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // [3:0] row, [8:4] col, [15:9] zero
	logic [1:0]  s_axis_tuser;   // [1:0] kind
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;   // [0] serial_data, [5:1] bit_position, [6] latch_after
	logic        m_axis_tlast;

	// idle chances in percent, changed per phase
	int src_idle_pct  = 8;
	int sink_idle_pct = 82;

	scan_frame_checker sb = new();

	led_matrix_scan_driver_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs; far above the slowest legal run
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// sink: random back-pressure, one decision per cycle
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// result monitor: every accepted bit goes to the checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_bit(m_axis_tdata[0], m_axis_tdata[5:1], m_axis_tdata[6], m_axis_tlast);
	end

	// Present one item and hold it until accepted. tvalid is left high afterwards so
	// back-to-back items never lower and raise it in the same step.
	task automatic send_item(logic [1:0] kind, logic [3:0] row, logic [4:0] col);
		if ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {7'b0, col, row};
		do @(posedge clk); while (!s_axis_tready);
		sb.take_item(kind, row, col);
	endtask

	// Stop sending and wait until every predicted bit is out, then keep the clock running
	// idle, since set, clear and quiet ticks leave nothing in the queue to wait on.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.bits_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle; the register takes it on the access edge.
	// The bus is then left idle so the next transfer starts in a later step.
	task automatic write_period(logic [PERIOD_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PERIOD_ADDR;
		pwdata  <= {{(32-PERIOD_W){1'b0}}, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.period = value;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// APB read-back of scan_period against the predicted value
	task automatic check_period();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= PERIOD_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[PERIOD_W-1:0] !== sb.period)
			sb.complain($sformatf("scan_period read: expected %0d, got %0d",
				sb.period, prdata[PERIOD_W-1:0]));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Random phase: mostly ticks and in-range sets, some clears, a little noise
	// (out-of-range positions, unused kind). Only items that act on the block count.
	task automatic run_phase(int src_pct, int sink_pct, logic [PERIOD_W-1:0] per, int n);
		int          acted;
		int unsigned pick;
		logic [1:0]  kind;
		logic [3:0]  row;
		logic [4:0]  col;
		settle();
		write_period(per);
		check_period();
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		acted = 0;
		while (acted < n) begin
			pick = $urandom_range(99);
			row  = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(7));
			col  = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(15));
			if (pick < 45)
				kind = KIND_TICK;
			else if (pick < 87)
				kind = KIND_SET;
			else if (pick < 92)
				kind = KIND_CLEAR;
			else
				kind = KIND_UNUSED;
			send_item(kind, row, col);
			if (kind == KIND_TICK || kind == KIND_CLEAR ||
			    (kind == KIND_SET && row < ROW_COUNT_DEF && col < COLUMN_COUNT_DEF))
				acted++;
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= KIND_TICK;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part, sender 8% / sink 82% idle ---
		check_period();                       // reset value
		send_item(KIND_TICK, 4'd0, 5'd0);     // first tick: no scan yet
		send_item(KIND_TICK, 4'd15, 5'd31);   // second tick scans row 0, still blank
		// corners of the frame plus one inside
		send_item(KIND_SET, 4'd0, 5'd0);
		send_item(KIND_SET, 4'd0, 5'd15);
		send_item(KIND_SET, 4'd7, 5'd0);
		send_item(KIND_SET, 4'd7, 5'd15);
		send_item(KIND_SET, 4'd3, 5'd9);
		// out-of-range row and column, unused kind: all ignored
		send_item(KIND_SET, 4'd8, 5'd3);
		send_item(KIND_SET, 4'd15, 5'd31);
		send_item(KIND_SET, 4'd2, 5'd16);
		send_item(KIND_SET, 4'd5, 5'd31);
		send_item(KIND_UNUSED, 4'd1, 5'd1);
		// zero period scans on every tick; eight ticks walk all rows and wrap to row 0
		settle();
		write_period('0);
		check_period();
		repeat (8) send_item(KIND_TICK, 4'd0, 5'd0);
		// clear, then a scan of the blank frame
		send_item(KIND_CLEAR, 4'd6, 5'd7);
		send_item(KIND_TICK, 4'd0, 5'd0);
		// longest period, a few ticks, then lower it below the count: next tick scans
		settle();
		write_period('1);
		check_period();
		send_item(KIND_SET, 4'd2, 5'd5);
		repeat (3) send_item(KIND_TICK, 4'd0, 5'd0);
		settle();
		write_period(PERIOD_W'(2));
		send_item(KIND_TICK, 4'd0, 5'd0);

		// --- random part: sink starved, then source starved, then full speed ---
		run_phase(8, 82, PERIOD_W'(1), 30);
		run_phase(82, 8, PERIOD_W'($urandom_range(2, 4)), 30);
		run_phase(0, 0, PERIOD_W'(2), 30);

		settle();
		if (sb.bits_due.size() != 0)
			sb.complain($sformatf("%0d scan bits never arrived", sb.bits_due.size()));
		if (sb.fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/lmsd_pkg.sv
rtl/lmsd_front.sv
rtl/lmsd_queue.sv
rtl/lmsd_back.sv
rtl/led_matrix_scan_driver_top.sv
bench/led_matrix_scan_driver_top_tb.sv
